/* src/ngga_pkg.sv */
// Shared types, character codes and helper functions for the NMEA GGA sentence parser.
// No dependencies; the parser core imports it.
`default_nettype none

package ngga_pkg;

  localparam int unsigned IdxW   = 7;
  localparam int unsigned AccW   = 17;
  localparam int unsigned OutDataW = 128;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_HEADER   = 3'd1,
    STAT_FORMAT   = 3'd2,
    STAT_CHECKSUM = 3'd3,
    STAT_LAT      = 3'd4,
    STAT_LON      = 3'd5,
    STAT_QUALITY  = 3'd6,
    STAT_SATS     = 3'd7
  } status_e;

  localparam logic [7:0] ChrDollar  = 8'h24;
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrStar    = 8'h2A;
  localparam logic [7:0] ChrComma   = 8'h2C;
  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrNine    = 8'h39;
  localparam logic [2:0] HdrLen     = 3'd6;
  localparam logic [3:0] CommaTotal = 4'd14;
  localparam logic [3:0] SatMax     = 4'd15;

  // Expected header text "$GPGGA", indexed by byte position.
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  // acc * 10 + digit; narrower accumulators keep the low bits of the result.
  function automatic logic [AccW-1:0] dec_push(input logic [AccW-1:0] acc,
                                               input logic [7:0] c);
    logic [AccW-1:0] d;
    d = AccW'(c - ChrZero);
    return (acc << 3) + (acc << 1) + d;
  endfunction

  // Hex digit to nibble: digits map directly, anything else as (c - 55) mod 16.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

`default_nettype wire

/* src/nmea_gga_sentence_parser_core.sv */
// NMEA GGA sentence parser: byte stream in, one status transaction per terminated sentence.
// Depends on ngga_pkg for status codes, character codes and digit helpers.
`default_nettype none

// The parser takes one sentence byte per clock cycle on s_axis, with tuser marking the
// first byte of a sentence. Each byte updates the sentence state in the same cycle it is
// accepted, so the rate is one byte per cycle, set only by the single output register:
// s_axis_tready drops only while a finished result sits in that register and m_axis_tready
// is low. The result for a sentence appears on m_axis in the cycle after its newline byte,
// or after byte MAX_LEN-1 when no newline arrives in time. Bytes outside a sentence are
// accepted and dropped.
module nmea_gga_sentence_parser_core
  import ngga_pkg::*;
#(
  parameter int unsigned MAX_LEN = 100
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] char_byte
  input  wire logic [0:0]          s_axis_tuser,   // [0] first
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] lat_degrees, [13:7] lat_minutes, [30:14] lat_fraction, [38:31] lat_hemisphere,
  // [48:39] lon_degrees, [55:49] lon_minutes, [72:56] lon_fraction, [80:73] lon_hemisphere,
  // [96:81] fix_quality, [112:97] satellites, [120:113] received_checksum, rest zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic [2:0]               m_axis_tuser    // [2:0] status
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_LEN - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            active_q, active_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [3:0]      commas_q, commas_d;
  logic            star_q, star_d;
  logic [IdxW-1:0] star_idx_q, star_idx_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      cksum_q, cksum_d;
  logic [3:0]      lat_off_q, lat_off_d;
  logic [3:0]      lon_off_q, lon_off_d;
  logic [6:0]      lat_deg_q, lat_deg_d;
  logic [6:0]      lat_min_q, lat_min_d;
  logic [16:0]     lat_frac_q, lat_frac_d;
  logic [7:0]      lat_hemi_q, lat_hemi_d;
  logic [9:0]      lon_deg_q, lon_deg_d;
  logic [6:0]      lon_min_q, lon_min_d;
  logic [16:0]     lon_frac_q, lon_frac_d;
  logic [7:0]      lon_hemi_q, lon_hemi_d;
  logic [15:0]     qual_q, qual_d;
  logic [15:0]     sats_q, sats_d;
  logic [3:0]      faults_q, faults_d;
  logic            prev_comma_q, prev_comma_d;

  logic                res_valid;
  status_e             res_status;
  logic [OutDataW-1:0] res_data;
  logic                in_accept;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  status_e             m_status_q;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_valid_q || m_axis_tready;

  always_comb begin
    logic [7:0]      c;
    logic [IdxW-1:0] bi;
    logic [IdxW:0]   star_end;
    logic            hdr;
    status_e         st;
    c          = s_axis_tdata;
    bi         = idx_q + IdxW'(1);
    star_end   = {1'b0, star_idx_q} + (IdxW+1)'(4);
    hdr        = hdr_ok_q;
    st         = STAT_OK;

    idx_d        = idx_q;
    active_d     = active_q;
    hdr_ok_d     = hdr_ok_q;
    commas_d     = commas_q;
    star_d       = star_q;
    star_idx_d   = star_idx_q;
    xor_d        = xor_q;
    cksum_d      = cksum_q;
    lat_off_d    = lat_off_q;
    lon_off_d    = lon_off_q;
    lat_deg_d    = lat_deg_q;
    lat_min_d    = lat_min_q;
    lat_frac_d   = lat_frac_q;
    lat_hemi_d   = lat_hemi_q;
    lon_deg_d    = lon_deg_q;
    lon_min_d    = lon_min_q;
    lon_frac_d   = lon_frac_q;
    lon_hemi_d   = lon_hemi_q;
    qual_d       = qual_q;
    sats_d       = sats_q;
    faults_d     = faults_q;
    prev_comma_d = prev_comma_q;
    res_valid    = 1'b0;

    if (in_accept) begin
      if (s_axis_tuser[0]) begin
        // Byte 0 of a new sentence: only the header check applies to it.
        idx_d        = '0;
        active_d     = 1'b1;
        hdr_ok_d     = (c == ChrDollar);
        commas_d     = '0;
        star_d       = 1'b0;
        star_idx_d   = '0;
        xor_d        = '0;
        cksum_d      = '0;
        lat_off_d    = '0;
        lon_off_d    = '0;
        lat_deg_d    = '0;
        lat_min_d    = '0;
        lat_frac_d   = '0;
        lat_hemi_d   = '0;
        lon_deg_d    = '0;
        lon_min_d    = '0;
        lon_frac_d   = '0;
        lon_hemi_d   = '0;
        qual_d       = '0;
        sats_d       = '0;
        faults_d     = '0;
        prev_comma_d = 1'b0;
      end else if (active_q) begin
        idx_d = bi;
        if ((bi < IdxW'(HdrLen)) && (c != hdr_char(bi[2:0]))) begin
          hdr = 1'b0;
        end
        hdr_ok_d = hdr;

        if (c == ChrNewline) begin
          if (!hdr) begin
            st = STAT_HEADER;
          end else if (!star_q || (commas_q != CommaTotal) || ({1'b0, bi} != star_end)) begin
            st = STAT_FORMAT;
          end else if (xor_q != cksum_q) begin
            st = STAT_CHECKSUM;
          end else if (faults_q[0]) begin
            st = STAT_LAT;
          end else if (faults_q[1]) begin
            st = STAT_LON;
          end else if (faults_q[2]) begin
            st = STAT_QUALITY;
          end else if (faults_q[3]) begin
            st = STAT_SATS;
          end else begin
            st = STAT_OK;
          end
          res_valid = 1'b1;
          active_d  = 1'b0;
        end else begin
          if (!star_q) begin
            if (c == ChrStar) begin
              star_d     = 1'b1;
              star_idx_d = bi;
            end else begin
              xor_d = xor_q ^ c;
            end
          end else if ((bi == star_idx_q + IdxW'(1)) || (bi == star_idx_q + IdxW'(2))) begin
            cksum_d = {cksum_q[3:0], hex_nibble(c)};
          end

          // Latitude digits sit at fixed offsets after the second comma.
          if (commas_q >= 4'd2) begin
            lat_off_d = (lat_off_q != SatMax) ? lat_off_q + 4'd1 : SatMax;
            if ((lat_off_d != 4'd5) && (lat_off_d <= 4'd10)) begin
              if (!is_dec(c)) begin
                faults_d[0] = 1'b1;
              end else if (lat_off_d <= 4'd2) begin
                lat_deg_d = 7'(dec_push(AccW'(lat_deg_q), c));
              end else if (lat_off_d <= 4'd4) begin
                lat_min_d = 7'(dec_push(AccW'(lat_min_q), c));
              end else begin
                lat_frac_d = dec_push(lat_frac_q, c);
              end
            end
          end

          // Longitude digits sit at fixed offsets after the fourth comma.
          if (commas_q >= 4'd4) begin
            lon_off_d = (lon_off_q != SatMax) ? lon_off_q + 4'd1 : SatMax;
            if ((lon_off_d != 4'd6) && (lon_off_d <= 4'd11)) begin
              if (!is_dec(c)) begin
                faults_d[1] = 1'b1;
              end else if (lon_off_d <= 4'd3) begin
                lon_deg_d = 10'(dec_push(AccW'(lon_deg_q), c));
              end else if (lon_off_d <= 4'd5) begin
                lon_min_d = 7'(dec_push(AccW'(lon_min_q), c));
              end else begin
                lon_frac_d = dec_push(lon_frac_q, c);
              end
            end
          end

          if (prev_comma_q && (commas_q == 4'd3)) begin
            lat_hemi_d = c;
          end
          if (prev_comma_q && (commas_q == 4'd5)) begin
            lon_hemi_d = c;
          end

          if (c != ChrComma) begin
            if (commas_q == 4'd6) begin
              if (is_dec(c)) begin
                qual_d = 16'(dec_push(AccW'(qual_q), c));
              end else begin
                faults_d[2] = 1'b1;
              end
            end else if (commas_q == 4'd7) begin
              if (is_dec(c)) begin
                sats_d = 16'(dec_push(AccW'(sats_q), c));
              end else begin
                faults_d[3] = 1'b1;
              end
            end
          end

          if (c == ChrComma) begin
            commas_d     = (commas_q != SatMax) ? commas_q + 4'd1 : SatMax;
            prev_comma_d = 1'b1;
          end else begin
            prev_comma_d = 1'b0;
          end

          // Sentence ran out of room without a newline.
          if (bi >= LastIdx) begin
            st        = hdr ? STAT_FORMAT : STAT_HEADER;
            res_valid = 1'b1;
            active_d  = 1'b0;
          end
        end
      end
    end
    res_status = st;
  end

  // Fields that a failing status does not vouch for read as zero.
  always_comb begin
    logic ck_en, lat_en, lon_en, q_en, s_en;
    ck_en  = (res_status == STAT_OK) || (res_status >= STAT_CHECKSUM);
    lat_en = (res_status == STAT_OK) || (res_status >= STAT_LON);
    lon_en = (res_status == STAT_OK) || (res_status >= STAT_QUALITY);
    q_en   = (res_status == STAT_OK) || (res_status == STAT_SATS);
    s_en   = (res_status == STAT_OK);
    res_data          = '0;
    res_data[6:0]     = lat_en ? lat_deg_q  : '0;
    res_data[13:7]    = lat_en ? lat_min_q  : '0;
    res_data[30:14]   = lat_en ? lat_frac_q : '0;
    res_data[38:31]   = lat_en ? lat_hemi_q : '0;
    res_data[48:39]   = lon_en ? lon_deg_q  : '0;
    res_data[55:49]   = lon_en ? lon_min_q  : '0;
    res_data[72:56]   = lon_en ? lon_frac_q : '0;
    res_data[80:73]   = lon_en ? lon_hemi_q : '0;
    res_data[96:81]   = q_en   ? qual_q     : '0;
    res_data[112:97]  = s_en   ? sats_q     : '0;
    res_data[120:113] = ck_en  ? cksum_q    : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      active_q     <= 1'b0;
      hdr_ok_q     <= 1'b1;
      commas_q     <= '0;
      star_q       <= 1'b0;
      star_idx_q   <= '0;
      xor_q        <= '0;
      cksum_q      <= '0;
      lat_off_q    <= '0;
      lon_off_q    <= '0;
      lat_deg_q    <= '0;
      lat_min_q    <= '0;
      lat_frac_q   <= '0;
      lat_hemi_q   <= '0;
      lon_deg_q    <= '0;
      lon_min_q    <= '0;
      lon_frac_q   <= '0;
      lon_hemi_q   <= '0;
      qual_q       <= '0;
      sats_q       <= '0;
      faults_q     <= '0;
      prev_comma_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      active_q     <= active_d;
      hdr_ok_q     <= hdr_ok_d;
      commas_q     <= commas_d;
      star_q       <= star_d;
      star_idx_q   <= star_idx_d;
      xor_q        <= xor_d;
      cksum_q      <= cksum_d;
      lat_off_q    <= lat_off_d;
      lon_off_q    <= lon_off_d;
      lat_deg_q    <= lat_deg_d;
      lat_min_q    <= lat_min_d;
      lat_frac_q   <= lat_frac_d;
      lat_hemi_q   <= lat_hemi_d;
      lon_deg_q    <= lon_deg_d;
      lon_min_q    <= lon_min_d;
      lon_frac_q   <= lon_frac_d;
      lon_hemi_q   <= lon_hemi_d;
      qual_q       <= qual_d;
      sats_q       <= sats_d;
      faults_q     <= faults_d;
      prev_comma_q <= prev_comma_d;
    end
  end

  // Output register: loads a new result whenever the previous one is gone or leaving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q   <= res_data;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

/* dv/nmea_gga_sentence_parser_checker.sv */
// Scoreboard for the NMEA GGA sentence parser: tracks each accepted byte, predicts status results.
// Compares every result transaction against the oldest prediction. Depends on ngga_pkg.

module nmea_gga_sentence_parser_checker
  import ngga_pkg::*;
#(
  parameter int unsigned MaxLen = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [2:0]          m_axis_tuser,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    status_e     status;
    logic [6:0]  lat_deg;
    logic [6:0]  lat_min;
    logic [16:0] lat_frac;
    logic [7:0]  lat_hemi;
    logic [9:0]  lon_deg;
    logic [6:0]  lon_min;
    logic [16:0] lon_frac;
    logic [7:0]  lon_hemi;
    logic [15:0] quality;
    logic [15:0] sats;
    logic [7:0]  cksum;
  } gga_fix_t;

  // "$GPGGA", first character in the top byte.
  localparam logic [47:0] GgaHeader = "$GPGGA";

  gga_fix_t    fix_q[$];

  bit          active;
  bit          hdr_ok;
  bit          star_seen;
  bit          prev_comma;
  int unsigned byte_idx;
  int unsigned star_idx;
  logic [3:0]  commas;
  logic [3:0]  lat_off;
  logic [3:0]  lon_off;
  logic [3:0]  faults;     // lat, lon, quality, satellites from bit 0 up
  logic [7:0]  xor_acc;
  logic [7:0]  cks;
  logic [6:0]  lat_deg;
  logic [6:0]  lat_min;
  logic [16:0] lat_frac;
  logic [7:0]  lat_hemi;
  logic [9:0]  lon_deg;
  logic [6:0]  lon_min;
  logic [16:0] lon_frac;
  logic [7:0]  lon_hemi;
  logic [15:0] quality;
  logic [15:0] sats;

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  task clear_state();
    byte_idx   = 0;
    hdr_ok     = 1'b1;
    commas     = '0;
    star_seen  = 1'b0;
    star_idx   = 0;
    xor_acc    = '0;
    cks        = '0;
    lat_off    = '0;
    lon_off    = '0;
    lat_deg    = '0;
    lat_min    = '0;
    lat_frac   = '0;
    lat_hemi   = '0;
    lon_deg    = '0;
    lon_min    = '0;
    lon_frac   = '0;
    lon_hemi   = '0;
    quality    = '0;
    sats       = '0;
    faults     = '0;
    prev_comma = 1'b0;
  endtask

  // Fields that a failing check makes meaningless are expected as zero.
  task emit_fix(input status_e st);
    gga_fix_t fx;
    fx = '0;
    fx.status = st;
    if (st == STAT_OK || st >= STAT_CHECKSUM) fx.cksum = cks;
    if (st == STAT_OK || st >= STAT_LON) begin
      fx.lat_deg  = lat_deg;
      fx.lat_min  = lat_min;
      fx.lat_frac = lat_frac;
      fx.lat_hemi = lat_hemi;
    end
    if (st == STAT_OK || st >= STAT_QUALITY) begin
      fx.lon_deg  = lon_deg;
      fx.lon_min  = lon_min;
      fx.lon_frac = lon_frac;
      fx.lon_hemi = lon_hemi;
    end
    if (st == STAT_OK || st == STAT_SATS) fx.quality = quality;
    if (st == STAT_OK) fx.sats = sats;
    fix_q.push_back(fx);
    active = 1'b0;
  endtask

  task predict_byte(input logic [7:0] c, input logic first);
    status_e    st;
    logic [7:0] diff;
    logic [3:0] nib;
    if (first) begin
      clear_state();
      active = 1'b1;
    end else begin
      if (!active) return;
      byte_idx = byte_idx + 1;
    end

    if (byte_idx < HdrLen && c != GgaHeader[8*(5-byte_idx) +: 8]) hdr_ok = 1'b0;
    if (byte_idx == 0) return;

    if (c == ChrNewline) begin
      if (!hdr_ok) st = STAT_HEADER;
      else if (!star_seen || commas != CommaTotal || byte_idx - star_idx != 4)
        st = STAT_FORMAT;
      else if (xor_acc != cks) st = STAT_CHECKSUM;
      else if (faults[0]) st = STAT_LAT;
      else if (faults[1]) st = STAT_LON;
      else if (faults[2]) st = STAT_QUALITY;
      else if (faults[3]) st = STAT_SATS;
      else st = STAT_OK;
      emit_fix(st);
      return;
    end

    if (!star_seen) begin
      if (c == ChrStar) begin
        star_seen = 1'b1;
        star_idx  = byte_idx;
      end else begin
        xor_acc = xor_acc ^ c;
      end
    end else if (byte_idx == star_idx + 1 || byte_idx == star_idx + 2) begin
      diff = c - 8'd55;
      nib  = is_digit(c) ? c[3:0] : diff[3:0];
      cks  = {cks[3:0], nib};
    end

    // Coordinate digits sit at fixed offsets from the comma that opens the field.
    if (commas >= 4'd2) begin
      if (lat_off < SatMax) lat_off = lat_off + 4'd1;
      if (lat_off != 4'd5 && lat_off <= 4'd10) begin
        if (!is_digit(c)) faults[0] = 1'b1;
        else if (lat_off <= 4'd2) lat_deg = lat_deg * 7'd10 + 7'(c - ChrZero);
        else if (lat_off <= 4'd4) lat_min = lat_min * 7'd10 + 7'(c - ChrZero);
        else lat_frac = lat_frac * 17'd10 + 17'(c - ChrZero);
      end
    end
    if (commas >= 4'd4) begin
      if (lon_off < SatMax) lon_off = lon_off + 4'd1;
      if (lon_off != 4'd6 && lon_off <= 4'd11) begin
        if (!is_digit(c)) faults[1] = 1'b1;
        else if (lon_off <= 4'd3) lon_deg = lon_deg * 10'd10 + 10'(c - ChrZero);
        else if (lon_off <= 4'd5) lon_min = lon_min * 7'd10 + 7'(c - ChrZero);
        else lon_frac = lon_frac * 17'd10 + 17'(c - ChrZero);
      end
    end
    if (prev_comma && commas == 4'd3) lat_hemi = c;
    if (prev_comma && commas == 4'd5) lon_hemi = c;
    if (c != ChrComma) begin
      if (commas == 4'd6) begin
        if (is_digit(c)) quality = quality * 16'd10 + 16'(c - ChrZero);
        else faults[2] = 1'b1;
      end else if (commas == 4'd7) begin
        if (is_digit(c)) sats = sats * 16'd10 + 16'(c - ChrZero);
        else faults[3] = 1'b1;
      end
    end

    if (c == ChrComma) begin
      if (commas < SatMax) commas = commas + 4'd1;
      prev_comma = 1'b1;
    end else begin
      prev_comma = 1'b0;
    end

    // Without a newline in time the sentence is closed on its last allowed byte.
    if (byte_idx >= MaxLen - 1) begin
      if (hdr_ok) emit_fix(STAT_FORMAT);
      else emit_fix(STAT_HEADER);
    end
  endtask

  task check_field(input string name, input longint unsigned want, input longint unsigned got);
    if (want != got) begin
      errors_o++;
      if (errors_o <= 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task check_fix();
    gga_fix_t want;
    if (fix_q.size() == 0) begin
      errors_o++;
      if (errors_o <= 10) $display("result with status %0d arrived unpredicted", m_axis_tuser);
      return;
    end
    want = fix_q.pop_front();
    check_field("status", want.status, m_axis_tuser);
    check_field("lat_degrees", want.lat_deg, m_axis_tdata[6:0]);
    check_field("lat_minutes", want.lat_min, m_axis_tdata[13:7]);
    check_field("lat_fraction", want.lat_frac, m_axis_tdata[30:14]);
    check_field("lat_hemisphere", want.lat_hemi, m_axis_tdata[38:31]);
    check_field("lon_degrees", want.lon_deg, m_axis_tdata[48:39]);
    check_field("lon_minutes", want.lon_min, m_axis_tdata[55:49]);
    check_field("lon_fraction", want.lon_frac, m_axis_tdata[72:56]);
    check_field("lon_hemisphere", want.lon_hemi, m_axis_tdata[80:73]);
    check_field("fix_quality", want.quality, m_axis_tdata[96:81]);
    check_field("satellites", want.sats, m_axis_tdata[112:97]);
    check_field("received_checksum", want.cksum, m_axis_tdata[120:113]);
    check_field("padding", 0, m_axis_tdata[127:121]);
  endtask

  // Results are checked before the byte of the same edge is predicted; a result
  // can only show up in the cycle after the byte that closed its sentence.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      active = 1'b0;
      fix_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_fix();
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tuser[0]);
      pending_o = fix_q.size();
    end
  end

endmodule

/* dv/tb_nmea_gga_sentence_parser_core.sv */
// Testbench top for the NMEA GGA sentence parser core: builds GGA sentences, good and damaged,
// and streams them under several idle and stall patterns. Depends on ngga_pkg and the checker.

module tb_nmea_gga_sentence_parser_core;
  import ngga_pkg::*;

  localparam int unsigned MaxLen        = 100;
  localparam int unsigned TotalBytes    = 1750;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  localparam logic [7:0] ChrCR     = 8'h0D;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrLowerA = 8'h61;

  // Damage applied to a sentence, as a bit mask.
  localparam int unsigned FlawHeader   = 1 << 0;
  localparam int unsigned FlawCommas   = 1 << 1;
  localparam int unsigned FlawNoStar   = 1 << 2;
  localparam int unsigned FlawStarPos  = 1 << 3;
  localparam int unsigned FlawChecksum = 1 << 4;
  localparam int unsigned FlawLat      = 1 << 5;
  localparam int unsigned FlawLon      = 1 << 6;
  localparam int unsigned FlawQuality  = 1 << 7;
  localparam int unsigned FlawSats     = 1 << 8;
  localparam int unsigned FlawLfFirst  = 1 << 9;
  localparam int unsigned FlawRunaway  = 1 << 10;
  localparam int unsigned FlawCut      = 1 << 11;
  localparam int unsigned FlawKinds    = 12;

  typedef struct {
    int unsigned lat_deg;
    int unsigned lat_min;
    int unsigned lat_frac;
    logic [7:0]  lat_hemi;
    int unsigned lon_deg;
    int unsigned lon_min;
    int unsigned lon_frac;
    logic [7:0]  lon_hemi;
    int unsigned qual_len;
    int unsigned qual_val;
    int unsigned sats_len;
    int unsigned sats_val;
  } gga_fields_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;

  int unsigned mismatches;
  int unsigned fixes_pending;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned bytes_sent = 0;
  bit          hold_req   = 1'b0;
  logic [7:0]  line_q[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nmea_gga_sentence_parser_core #(
    .MAX_LEN(MaxLen)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  nmea_gga_sentence_parser_checker #(
    .MaxLen(MaxLen)
  ) fix_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors_o     (mismatches),
    .pending_o    (fixes_pending)
  );

  function automatic int unsigned p10(input int unsigned n);
    int unsigned v;
    v = 1;
    repeat (n) v = v * 10;
    return v;
  endfunction

  // A byte that is neither a digit nor one of the characters that steer the parser.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= ChrZero && c <= ChrNine) || c == ChrComma || c == ChrStar || c == ChrNewline);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return ChrZero + 8'(n);
    return (lower ? ChrLowerA : ChrUpperA) + 8'(n) - 8'd10;
  endfunction

  function automatic gga_fields_t random_fields();
    gga_fields_t f;
    int unsigned r;
    f.lat_deg  = $urandom_range(0, 99);
    f.lat_min  = $urandom_range(0, 99);
    f.lat_frac = $urandom_range(0, 99999);
    f.lat_hemi = ($urandom_range(0, 9) == 0) ? junk_char() : ($urandom_range(0, 1) ? "N" : "S");
    f.lon_deg  = $urandom_range(0, 999);
    f.lon_min  = $urandom_range(0, 99);
    f.lon_frac = $urandom_range(0, 99999);
    f.lon_hemi = ($urandom_range(0, 9) == 0) ? junk_char() : ($urandom_range(0, 1) ? "E" : "W");
    r = $urandom_range(0, 9);
    f.qual_len = (r == 0) ? 0 : (r < 8) ? 1 : $urandom_range(2, 7);
    f.qual_val = $urandom % p10(f.qual_len);
    r = $urandom_range(0, 9);
    f.sats_len = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 2) : $urandom_range(3, 9);
    f.sats_val = $urandom % p10(f.sats_len);
    return f;
  endfunction

  // Mostly clean sentences; the rest carry one or two faults, are cut short or never end.
  function automatic int unsigned random_flaws();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return 1 << $urandom_range(0, 9);
    if (r < 91) return (1 << $urandom_range(0, 9)) | (1 << $urandom_range(0, 9));
    if (r < 96) return FlawCut;
    return FlawRunaway;
  endfunction

  task push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task push_dec(input int unsigned v, input int unsigned n);
    int unsigned i;
    for (i = n; i > 0; i--) line_q.push_back(8'(ChrZero + (v / p10(i - 1)) % 10));
  endtask

  task build_gga(input gga_fields_t f, input int unsigned flaws);
    logic [7:0] cks;
    int         at;
    int         slot;
    int         k;
    bit         lower;
    lower = ($urandom_range(0, 2) == 0);
    line_q.delete();
    push_text("$GPGGA,");
    push_dec($urandom_range(0, 235959), 6);
    push_text(".");
    push_dec($urandom_range(0, 99), 2);
    push_text(",");
    at = line_q.size();
    push_dec(f.lat_deg, 2);
    push_dec(f.lat_min, 2);
    push_text(".");
    push_dec(f.lat_frac, 5);
    if (flaws & FlawLat) begin
      slot = $urandom_range(0, 8);
      if (slot >= 4) slot++;
      line_q[at + slot] = junk_char();
    end
    line_q.push_back(ChrComma);
    line_q.push_back(f.lat_hemi);
    line_q.push_back(ChrComma);
    at = line_q.size();
    push_dec(f.lon_deg, 3);
    push_dec(f.lon_min, 2);
    push_text(".");
    push_dec(f.lon_frac, 5);
    if (flaws & FlawLon) begin
      slot = $urandom_range(0, 9);
      if (slot >= 5) slot++;
      line_q[at + slot] = junk_char();
    end
    line_q.push_back(ChrComma);
    line_q.push_back(f.lon_hemi);
    line_q.push_back(ChrComma);
    push_dec(f.qual_val, f.qual_len);
    if (flaws & FlawQuality) line_q.push_back(junk_char());
    line_q.push_back(ChrComma);
    push_dec(f.sats_val, f.sats_len);
    if (flaws & FlawSats) line_q.push_back(junk_char());
    push_text(",0.9,12.3,M,-3.1,M,,");
    push_dec($urandom_range(0, 9999), $urandom_range(0, 4));

    if (flaws & FlawCommas) begin
      if ($urandom_range(0, 1)) begin
        line_q.push_back(ChrComma);
      end else begin
        k = line_q.size() - 1;
        while (line_q[k] != ChrComma) k--;
        line_q.delete(k);
      end
    end
    if (flaws & FlawHeader) begin
      slot = $urandom_range(0, 5);
      line_q[slot] = line_q[slot] ^ 8'($urandom_range(1, 255));
    end
    if (flaws & FlawLfFirst) line_q[0] = ChrNewline;

    cks = '0;
    for (k = 1; k < line_q.size(); k++) cks = cks ^ line_q[k];
    if (flaws & FlawChecksum) cks = cks ^ 8'($urandom_range(1, 255));
    if (!(flaws & FlawNoStar)) line_q.push_back(ChrStar);
    line_q.push_back(hex_char(cks[7:4], lower));
    line_q.push_back(hex_char(cks[3:0], lower));
    // A misplaced terminator lands one byte early or one byte late.
    if (flaws & FlawStarPos) begin
      if ($urandom_range(0, 1)) begin
        line_q.push_back(ChrCR);
        line_q.push_back(ChrCR);
      end
    end else begin
      line_q.push_back(ChrCR);
    end
    if (flaws & FlawRunaway) begin
      while (line_q.size() < MaxLen + 3) begin
        do cks = 8'($urandom_range(0, 255));
        while (cks == ChrNewline);
        line_q.push_back(cks);
      end
    end else begin
      line_q.push_back(ChrNewline);
    end
    if (flaws & FlawCut) begin
      at = $urandom_range(1, line_q.size() - 2);
      while (line_q.size() > at) void'(line_q.pop_back());
    end
  endtask

  task send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == 0);
  endtask

  task send_noise();
    int n;
    line_q.delete();
    n = $urandom_range(1, 130);
    repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
    send_line();
  endtask

  // Bytes without a start mark; dropped unless an earlier sentence is still open.
  task send_loose_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    gga_fields_t f;
    int unsigned idle_of[4];
    int unsigned stall_of[4];
    int unsigned ph;
    int unsigned i;
    int unsigned base;
    int unsigned budget;
    idle_of  = '{0, 47, 0, 11};
    stall_of = '{0, 0, 47, 11};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clean sentence, field extremes, empty fields, each fault alone, pairs, noise.
    build_gga(random_fields(), 0);
    send_line();
    send_loose_bytes(3);
    f = random_fields();
    f.lat_deg  = 99;
    f.lat_min  = 99;
    f.lat_frac = 99999;
    f.lon_deg  = 999;
    f.lon_min  = 99;
    f.lon_frac = 99999;
    f.qual_len = 7;
    f.qual_val = 9999999;
    f.sats_len = 9;
    f.sats_val = 999999999;
    build_gga(f, 0);
    send_line();
    f.lat_deg  = 0;
    f.lat_min  = 0;
    f.lat_frac = 0;
    f.lon_deg  = 0;
    f.lon_min  = 0;
    f.lon_frac = 0;
    f.qual_len = 0;
    f.sats_len = 0;
    build_gga(f, 0);
    send_line();
    for (i = 0; i < FlawKinds; i++) begin
      build_gga(random_fields(), 1 << i);
      send_line();
    end
    build_gga(random_fields(), FlawLat | FlawSats);
    send_line();
    build_gga(random_fields(), FlawChecksum | FlawLon);
    send_line();
    build_gga(random_fields(), FlawQuality | FlawSats);
    send_line();
    send_noise();

    // The remaining byte budget is split evenly over the four traffic phases.
    base   = bytes_sent;
    budget = (TotalBytes > base) ? TotalBytes - base : 0;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_of[ph];
      stall_pct = stall_of[ph];
      if (ph == 0) hold_req = 1'b1;
      do begin
        if ($urandom_range(0, 99) < 10) send_loose_bytes($urandom_range(1, 4));
        if ($urandom_range(0, 99) < 4) begin
          send_noise();
        end else begin
          build_gga(random_fields(), random_flaws());
          send_line();
        end
      end while (bytes_sent < base + (budget * (ph + 1)) / 4);
    end
    build_gga(random_fields(), 0);
    send_line();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (fixes_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
